[rtl/pps_pkg.sv]
// shared types, codes and defaults for the paced pull scheduler
// no dependencies; every other file refers to this package by scoped names
package pps_pkg;

    // default sizes, handed to the top level parameters
    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_CONNECTIONS = 256;
    localparam int DEF_TIME_BITS   = 32;
    localparam int DEF_PULL_BITS   = 16;

    // fixed field widths
    localparam int CMD_W      = 2;
    localparam int CONN_W     = 8;
    localparam int NOW_W      = 32;
    localparam int KIND_W     = 2;
    localparam int SEQ_W      = 16;
    localparam int TXQ_W      = 16;
    localparam int INTERVAL_W = 32;
    localparam int S_TDATA_W  = 40;   // conn_index, now
    localparam int M_TDATA_W  = 40;   // pull_conn, pull_seq, pull_txq

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIO_EN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TXQ      = 2'd2;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RST = 32'd1000;

    // command codes on the input tuser
    localparam logic [CMD_W-1:0] CMD_TICK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENQ_NORM = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ENQ_PRIO = 2'd2;

    // result kinds on the output tuser
    localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PULL = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DROP = 2'd2;

    // front-to-back item queue
    localparam int ITEM_Q_DEPTH = 4;
    localparam int IQ_PTR_W     = 2;
    localparam int IQ_CNT_W     = 3;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_ENQ_NORM,
        OP_ENQ_PRIO,
        OP_NONE
    } t_op;

    typedef struct packed {
        t_op               op;
        logic [CONN_W-1:0] conn;
        logic [NOW_W-1:0]  now;
    } t_item;

    typedef struct packed {
        logic [INTERVAL_W-1:0] interval;
        logic                  prio_en;
        logic [TXQ_W-1:0]      txq;
    } t_cfg;

    typedef enum logic [2:0] {
        BS_CLEAR,
        BS_IDLE,
        BS_EVAL,
        BS_QRD,
        BS_CRD
    } t_bstate;

endpackage

[rtl/pps_front.sv]
// front end: takes input beats, decodes the command and queues the items
// depends on pps_pkg
module pps_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [pps_pkg::CMD_W-1:0]     i_cmd,
    input  logic [pps_pkg::CONN_W-1:0]    i_conn,
    input  logic [pps_pkg::NOW_W-1:0]     i_now,
    input  logic                          i_hold,
    output logic                          o_item_valid,
    output pps_pkg::t_item                o_item,
    input  logic                          i_item_pop
);

    pps_pkg::t_item                r_q_mem [pps_pkg::ITEM_Q_DEPTH];
    logic [pps_pkg::IQ_PTR_W-1:0]  r_wr_ptr, n_wr_ptr;
    logic [pps_pkg::IQ_PTR_W-1:0]  r_rd_ptr, n_rd_ptr;
    logic [pps_pkg::IQ_CNT_W-1:0]  r_count, n_count;
    pps_pkg::t_item                dec_item;
    logic                          push;
    logic                          pop;

    // command decode
    always_comb begin
        dec_item.conn = i_conn;
        dec_item.now  = i_now;
        unique case (i_cmd)
            pps_pkg::CMD_TICK:     dec_item.op = pps_pkg::OP_TICK;
            pps_pkg::CMD_ENQ_NORM: dec_item.op = pps_pkg::OP_ENQ_NORM;
            pps_pkg::CMD_ENQ_PRIO: dec_item.op = pps_pkg::OP_ENQ_PRIO;
            default:               dec_item.op = pps_pkg::OP_NONE;
        endcase
    end

    assign o_ready      = (r_count != pps_pkg::IQ_CNT_W'(pps_pkg::ITEM_Q_DEPTH)) && !i_hold;
    assign push         = i_valid && o_ready;
    assign o_item_valid = (r_count != '0);
    assign pop          = i_item_pop && o_item_valid;
    assign o_item       = r_q_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q_mem[r_wr_ptr] <= dec_item;
        end
    end

endmodule

[rtl/pps_connq.sv]
// connection index queue: ring buffer in a memory with registered head read
// depends on pps_pkg
module pps_connq #(
    parameter int DEPTH = pps_pkg::DEF_QUEUE_DEPTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  logic [pps_pkg::CONN_W-1:0]  i_push_data,
    input  logic                        i_pop,
    output logic                        o_full,
    output logic                        o_empty,
    output logic [pps_pkg::CONN_W-1:0]  o_head_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [pps_pkg::CONN_W-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0]           r_head, n_head;
    logic [PTR_W-1:0]           r_tail, n_tail;
    logic [CNT_W-1:0]           r_count, n_count;
    logic [pps_pkg::CONN_W-1:0] r_rdata;
    logic                       do_push;
    logic                       do_pop;

    assign o_full      = (r_count == CNT_W'(DEPTH));
    assign o_empty     = (r_count == '0);
    assign do_push     = i_push && !o_full;
    assign do_pop      = i_pop && !o_empty;
    assign o_head_data = r_rdata;

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_count = r_count;
        if (do_push) begin
            n_tail = (r_tail == LAST) ? '0 : r_tail + 1'b1;
        end
        if (do_pop) begin
            n_head = (r_head == LAST) ? '0 : r_head + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_tail] <= i_push_data;
        end
        r_rdata <= r_mem[r_head];
    end

endmodule

[rtl/pps_back.sv]
// back end: runs one item at a time against the connection queues, the pull
// counter store and the pacing state; holds the output register
// depends on pps_pkg and pps_connq
module pps_back #(
    parameter int QUEUE_DEPTH = pps_pkg::DEF_QUEUE_DEPTH,
    parameter int CONNECTIONS = pps_pkg::DEF_CONNECTIONS,
    parameter int TIME_BITS   = pps_pkg::DEF_TIME_BITS,
    parameter int PULL_BITS   = pps_pkg::DEF_PULL_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_item_valid,
    input  pps_pkg::t_item              i_item,
    output logic                        o_item_pop,
    input  pps_pkg::t_cfg               i_cfg,
    output logic                        o_clearing,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [pps_pkg::KIND_W-1:0]  o_kind,
    output logic [pps_pkg::CONN_W-1:0]  o_conn,
    output logic [pps_pkg::SEQ_W-1:0]   o_seq,
    output logic [pps_pkg::TXQ_W-1:0]   o_txq
);

    localparam int CIDX_W = $clog2(CONNECTIONS);
    localparam int CMP_W  = (TIME_BITS > pps_pkg::INTERVAL_W) ? TIME_BITS : pps_pkg::INTERVAL_W;
    localparam logic [CIDX_W-1:0] CLR_LAST = CIDX_W'(CONNECTIONS - 1);

    // connection index mod CONNECTIONS by shift and subtract over the 8 bits
    function automatic logic [CIDX_W-1:0] f_cidx(input logic [pps_pkg::CONN_W-1:0] c);
        logic [pps_pkg::CONN_W:0] v_rem;
        v_rem = '0;
        for (int i = pps_pkg::CONN_W - 1; i >= 0; i--) begin
            v_rem = {v_rem[pps_pkg::CONN_W-1:0], c[i]};
            if ((CONNECTIONS < (1 << pps_pkg::CONN_W)) &&
                (v_rem >= (pps_pkg::CONN_W + 1)'(CONNECTIONS))) begin
                v_rem = v_rem - (pps_pkg::CONN_W + 1)'(CONNECTIONS);
            end
        end
        return CIDX_W'(v_rem);
    endfunction

    pps_pkg::t_bstate           r_state, n_state;
    logic [CIDX_W-1:0]          r_clr, n_clr;
    pps_pkg::t_op               r_op, n_op;
    logic [pps_pkg::CONN_W-1:0] r_conn, n_conn;
    logic [TIME_BITS-1:0]       r_now, n_now;
    logic [TIME_BITS-1:0]       r_next_due, n_next_due;
    logic                       r_idle, n_idle;
    logic                       r_sel_prio, n_sel_prio;
    logic                       r_out_valid, n_out_valid;
    logic [pps_pkg::KIND_W-1:0] r_out_kind, n_out_kind;
    logic [pps_pkg::CONN_W-1:0] r_out_conn, n_out_conn;
    logic [pps_pkg::SEQ_W-1:0]  r_out_seq, n_out_seq;
    logic [pps_pkg::TXQ_W-1:0]  r_out_txq, n_out_txq;

    // pull counter store
    logic [PULL_BITS-1:0]       r_cnt_mem [CONNECTIONS];
    logic [PULL_BITS-1:0]       r_cnt_rdata;
    logic                       cnt_we;
    logic [CIDX_W-1:0]          cnt_waddr;
    logic [PULL_BITS-1:0]       cnt_wdata;
    logic [CIDX_W-1:0]          cnt_raddr;

    // connection queues
    logic                       push_norm, push_prio;
    logic                       pop_norm, pop_prio;
    logic                       norm_full, norm_empty, prio_full, prio_empty;
    logic [pps_pkg::CONN_W-1:0] norm_head, prio_head, q_head;

    logic [TIME_BITS-1:0]       due_diff;
    logic                       due;
    logic [PULL_BITS-1:0]       seq;

    pps_connq #(.DEPTH(QUEUE_DEPTH)) u_normq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_norm),
        .i_push_data (r_conn),
        .i_pop       (pop_norm),
        .o_full      (norm_full),
        .o_empty     (norm_empty),
        .o_head_data (norm_head)
    );

    pps_connq #(.DEPTH(QUEUE_DEPTH)) u_prioq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push_prio),
        .i_push_data (r_conn),
        .i_pop       (pop_prio),
        .o_full      (prio_full),
        .o_empty     (prio_empty),
        .o_head_data (prio_head)
    );

    assign q_head    = r_sel_prio ? prio_head : norm_head;
    assign cnt_raddr = f_cidx(q_head);
    assign due_diff  = r_next_due - r_now;
    assign due       = CMP_W'(due_diff) > CMP_W'(i_cfg.interval);
    assign seq       = r_cnt_rdata + 1'b1;

    assign o_clearing = (r_state == pps_pkg::BS_CLEAR);
    assign o_valid    = r_out_valid;
    assign o_kind     = r_out_kind;
    assign o_conn     = r_out_conn;
    assign o_seq      = r_out_seq;
    assign o_txq      = r_out_txq;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_op        = r_op;
        n_conn      = r_conn;
        n_now       = r_now;
        n_next_due  = r_next_due;
        n_idle      = r_idle;
        n_sel_prio  = r_sel_prio;
        n_out_valid = r_out_valid && !i_ready;
        n_out_kind  = r_out_kind;
        n_out_conn  = r_out_conn;
        n_out_seq   = r_out_seq;
        n_out_txq   = r_out_txq;
        o_item_pop  = 1'b0;
        cnt_we      = 1'b0;
        cnt_waddr   = f_cidx(q_head);
        cnt_wdata   = seq;
        push_norm   = 1'b0;
        push_prio   = 1'b0;
        pop_norm    = 1'b0;
        pop_prio    = 1'b0;

        unique case (r_state)
            pps_pkg::BS_CLEAR: begin
                cnt_we    = 1'b1;
                cnt_waddr = r_clr;
                cnt_wdata = '0;
                if (r_clr == CLR_LAST) begin
                    n_state = pps_pkg::BS_IDLE;
                end else begin
                    n_clr = r_clr + 1'b1;
                end
            end

            pps_pkg::BS_IDLE: begin
                // start only when the output register is free by next cycle
                if (i_item_valid && (!r_out_valid || i_ready)) begin
                    o_item_pop = 1'b1;
                    n_op       = i_item.op;
                    n_conn     = i_item.conn;
                    n_now      = TIME_BITS'(i_item.now);
                    n_state    = pps_pkg::BS_EVAL;
                end
            end

            pps_pkg::BS_EVAL: begin
                n_state     = pps_pkg::BS_IDLE;
                n_out_valid = 1'b1;
                n_out_kind  = pps_pkg::KIND_NONE;
                n_out_conn  = '0;
                n_out_seq   = '0;
                n_out_txq   = '0;
                unique case (r_op)
                    pps_pkg::OP_ENQ_NORM: begin
                        if (norm_full) begin
                            n_out_kind = pps_pkg::KIND_DROP;
                        end else begin
                            push_norm = 1'b1;
                        end
                    end
                    pps_pkg::OP_ENQ_PRIO: begin
                        if (prio_full) begin
                            n_out_kind = pps_pkg::KIND_DROP;
                        end else begin
                            push_prio = 1'b1;
                        end
                    end
                    pps_pkg::OP_TICK: begin
                        if (due) begin
                            if (i_cfg.prio_en && !prio_empty) begin
                                n_sel_prio  = 1'b1;
                                n_out_valid = r_out_valid && !i_ready;
                                n_state     = pps_pkg::BS_QRD;
                            end else if (!norm_empty) begin
                                n_sel_prio  = 1'b0;
                                n_out_valid = r_out_valid && !i_ready;
                                n_state     = pps_pkg::BS_QRD;
                            end else begin
                                n_next_due = r_now;
                                n_idle     = 1'b1;
                            end
                        end
                    end
                    pps_pkg::OP_NONE: begin
                        n_out_kind = pps_pkg::KIND_NONE;
                    end
                endcase
            end

            pps_pkg::BS_QRD: begin
                // head entry is settled; counter read is issued from it
                n_state = pps_pkg::BS_CRD;
            end

            pps_pkg::BS_CRD: begin
                cnt_we      = 1'b1;
                pop_prio    = r_sel_prio;
                pop_norm    = !r_sel_prio;
                n_next_due  = TIME_BITS'(CMP_W'(r_idle ? r_now : r_next_due) +
                                         CMP_W'(i_cfg.interval));
                n_idle      = 1'b0;
                n_out_valid = 1'b1;
                n_out_kind  = pps_pkg::KIND_PULL;
                n_out_conn  = q_head;
                n_out_seq   = pps_pkg::SEQ_W'(seq);
                n_out_txq   = i_cfg.txq;
                n_state     = pps_pkg::BS_IDLE;
            end

            default: begin
                n_state = pps_pkg::BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pps_pkg::BS_CLEAR;
            r_clr       <= '0;
            r_next_due  <= '0;
            r_idle      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_next_due  <= n_next_due;
            r_idle      <= n_idle;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_conn     <= n_conn;
        r_now      <= n_now;
        r_sel_prio <= n_sel_prio;
        r_out_kind <= n_out_kind;
        r_out_conn <= n_out_conn;
        r_out_seq  <= n_out_seq;
        r_out_txq  <= n_out_txq;
    end

    always_ff @(posedge i_clk) begin
        if (cnt_we) begin
            r_cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        r_cnt_rdata <= r_cnt_mem[cnt_raddr];
    end

endmodule

[rtl/paced_pull_scheduler_top.sv]
// top level of the paced pull scheduler: stream ports, configuration registers
// depends on pps_pkg, pps_front, pps_back (and pps_connq below it)
//
//  channel   direction  tvalid/tready handshake  tdata / tuser
//  s_axis    in         tick or enqueue beat      {now, conn_index} / cmd
//  m_axis    out        one result per input beat {pull_txq, pull_seq, pull_conn} / kind
//  cfg       in         write on i_cfg_we         i_cfg_index, i_cfg_data
//
// - after reset a clearing pass zeroes all CONNECTIONS pull counters, with
//   s_axis_tready low; configuration writes are taken throughout
// - the back end holds one item at a time: an enqueue, a no-op or a tick with
//   no pull runs IDLE then EVAL; a pull goes on through QRD and CRD (queue
//   memory read, then counter memory read, each registered)
// - with the back end free, a result enters the output register from EVAL
//   (pull: CRD); a four-entry item queue keeps taking beats while the back end works
// - a stalled m_axis holds the result; the back end starts the next item only
//   once the output register is taken
module paced_pull_scheduler_top #(
    parameter int QUEUE_DEPTH = pps_pkg::DEF_QUEUE_DEPTH,
    parameter int CONNECTIONS = pps_pkg::DEF_CONNECTIONS,
    parameter int TIME_BITS   = pps_pkg::DEF_TIME_BITS,
    parameter int PULL_BITS   = pps_pkg::DEF_PULL_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input beats
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [pps_pkg::S_TDATA_W-1:0]      s_axis_tdata,  // conn_index[7:0], now[39:8]
    input  logic [pps_pkg::CMD_W-1:0]          s_axis_tuser,  // cmd[1:0]
    // result beats
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [pps_pkg::M_TDATA_W-1:0]      m_axis_tdata,  // pull_conn[7:0], pull_seq[23:8],
                                                              // pull_txq[39:24]
    output logic [pps_pkg::KIND_W-1:0]         m_axis_tuser,  // kind[1:0]
    // configuration writes
    input  logic                               i_cfg_we,
    input  logic [pps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [pps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    pps_pkg::t_cfg              r_cfg, n_cfg;
    pps_pkg::t_item             item;
    logic                       item_valid;
    logic                       item_pop;
    logic                       clearing;
    logic [pps_pkg::KIND_W-1:0] out_kind;
    logic [pps_pkg::CONN_W-1:0] out_conn;
    logic [pps_pkg::SEQ_W-1:0]  out_seq;
    logic [pps_pkg::TXQ_W-1:0]  out_txq;

    // configuration registers
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                pps_pkg::CFG_INTERVAL: n_cfg.interval = i_cfg_data;
                pps_pkg::CFG_PRIO_EN:  n_cfg.prio_en  = i_cfg_data[0];
                pps_pkg::CFG_TXQ:      n_cfg.txq      = i_cfg_data[pps_pkg::TXQ_W-1:0];
                default:               n_cfg          = r_cfg;  // unmapped index
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.interval <= pps_pkg::INTERVAL_RST;
            r_cfg.prio_en  <= 1'b0;
            r_cfg.txq      <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    // accept and decode
    pps_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_cmd        (s_axis_tuser),
        .i_conn       (s_axis_tdata[pps_pkg::CONN_W-1:0]),
        .i_now        (s_axis_tdata[pps_pkg::CONN_W +: pps_pkg::NOW_W]),
        .i_hold       (clearing),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_pop   (item_pop)
    );

    // queues, counters and pacing
    pps_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .CONNECTIONS (CONNECTIONS),
        .TIME_BITS   (TIME_BITS),
        .PULL_BITS   (PULL_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .o_item_pop   (item_pop),
        .i_cfg        (r_cfg),
        .o_clearing   (clearing),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_kind       (out_kind),
        .o_conn       (out_conn),
        .o_seq        (out_seq),
        .o_txq        (out_txq)
    );

    // result packing, lowest field first
    assign m_axis_tdata = {out_txq, out_seq, out_conn};
    assign m_axis_tuser = out_kind;

endmodule

[rtl/pps_checker.sv]
// port-level checks for the paced pull scheduler, bound to the top level
// depends on pps_pkg and paced_pull_scheduler_top
module pps_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               s_axis_tready,
    input logic                               m_axis_tvalid,
    input logic                               m_axis_tready,
    input logic [pps_pkg::M_TDATA_W-1:0]      m_axis_tdata,
    input logic [pps_pkg::KIND_W-1:0]         m_axis_tuser,
    input logic                               i_cfg_we,
    input logic [pps_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input logic [pps_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    logic [pps_pkg::TXQ_W-1:0] r_txq;

    // shadow of the transmit queue register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_txq <= '0;
        end else if (i_cfg_we && (i_cfg_index == pps_pkg::CFG_TXQ)) begin
            r_txq <= i_cfg_data[pps_pkg::TXQ_W-1:0];
        end
    end

    // counter clearing pass blocks input right after reset
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_rst_n) |-> !s_axis_tready)
        else $error("input ready during counter clearing");

    // results other than a pull carry an all-zero payload
    a_zero_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser != pps_pkg::KIND_PULL)) |-> (m_axis_tdata == '0))
        else $error("non-pull result with payload");

    // a pull is stamped with the configured transmit queue
    a_pull_txq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tuser == pps_pkg::KIND_PULL)) |->
        (m_axis_tdata[pps_pkg::M_TDATA_W-1 -: pps_pkg::TXQ_W] == r_txq))
        else $error("pull with wrong transmit queue");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
        (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

endmodule

bind paced_pull_scheduler_top pps_checker u_pps_checker (.*);

[bench/tb_paced_pull_scheduler_top.sv]
`timescale 1ns / 100ps
// self-checking bench for paced_pull_scheduler_top: directed and random beats,
// a scoreboard class with its own pacer model, random sender bursts and receiver stalls
// depends on pps_pkg and the rtl of paced_pull_scheduler_top

// one result beat as the bench sees it
typedef struct packed {
    logic [pps_pkg::KIND_W-1:0] kind;
    logic [pps_pkg::CONN_W-1:0] conn;
    logic [pps_pkg::SEQ_W-1:0]  seq;
    logic [pps_pkg::TXQ_W-1:0]  txq;
} t_pull_beat;

class pull_scoreboard;
    // register copies
    logic [31:0] pace_interval;
    bit          prio_on;
    logic [15:0] stamp_txq;
    // pacer state
    logic [7:0]  normal_waiting[$];
    logic [7:0]  prio_waiting[$];
    logic [15:0] pulls_sent[pps_pkg::DEF_CONNECTIONS];
    logic [31:0] deadline;
    bit          was_idle;
    // results still owed by the block
    t_pull_beat  owed_results[$];
    int          errors;

    function new();
        pace_interval = pps_pkg::INTERVAL_RST;
        prio_on = 1'b0;
        stamp_txq = '0;
        foreach (pulls_sent[i]) pulls_sent[i] = '0;
        deadline = '0;
        was_idle = 1'b1;
        errors = 0;
    endfunction

    function int pending();
        return owed_results.size();
    endfunction

    function void set_reg(logic [pps_pkg::CFG_IDX_W-1:0] idx, logic [31:0] value);
        case (idx)
            pps_pkg::CFG_INTERVAL: pace_interval = value;
            pps_pkg::CFG_PRIO_EN:  prio_on = value[0];
            pps_pkg::CFG_TXQ:      stamp_txq = value[15:0];
            default: ;
        endcase
    endfunction

    // works out the result of one accepted input beat
    function void take_item(logic [1:0] cmd, logic [7:0] conn, logic [31:0] now);
        t_pull_beat  r;
        logic [31:0] slack;
        logic [7:0]  c;
        bit          have;
        r = '0;
        have = 1'b0;
        c = '0;
        case (pps_pkg::t_op'(cmd))
            pps_pkg::OP_ENQ_NORM: begin
                if (normal_waiting.size() >= pps_pkg::DEF_QUEUE_DEPTH) r.kind = pps_pkg::KIND_DROP;
                else normal_waiting.push_back(conn);
            end
            pps_pkg::OP_ENQ_PRIO: begin
                if (prio_waiting.size() >= pps_pkg::DEF_QUEUE_DEPTH) r.kind = pps_pkg::KIND_DROP;
                else prio_waiting.push_back(conn);
            end
            pps_pkg::OP_TICK: begin
                slack = deadline - now;
                if (slack > pace_interval) begin
                    if (prio_on && prio_waiting.size() > 0) begin
                        c = prio_waiting.pop_front();
                        have = 1'b1;
                    end else if (normal_waiting.size() > 0) begin
                        c = normal_waiting.pop_front();
                        have = 1'b1;
                    end
                    if (have) begin
                        pulls_sent[c] = pulls_sent[c] + 16'd1;
                        r.kind = pps_pkg::KIND_PULL;
                        r.conn = c;
                        r.seq  = pulls_sent[c];
                        r.txq  = stamp_txq;
                        deadline = was_idle ? now + pace_interval : deadline + pace_interval;
                        was_idle = 1'b0;
                    end else begin
                        deadline = now;
                        was_idle = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        owed_results.push_back(r);
    endfunction

    task report_mismatch(string what);
        errors++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task check_beat(logic [1:0] kind, logic [39:0] data);
        t_pull_beat e;
        if (owed_results.size() == 0) begin
            report_mismatch("result beat with nothing outstanding");
            return;
        end
        e = owed_results.pop_front();
        if (kind !== e.kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind, e.kind));
        if (data[7:0] !== e.conn)
            report_mismatch($sformatf("pull_conn %0h, want %0h", data[7:0], e.conn));
        if (data[23:8] !== e.seq)
            report_mismatch($sformatf("pull_seq %0h, want %0h", data[23:8], e.seq));
        if (data[39:24] !== e.txq)
            report_mismatch($sformatf("pull_txq %0h, want %0h", data[39:24], e.txq));
    endtask
endclass

module tb_paced_pull_scheduler_top;

    // no named code for the spare command value
    localparam logic [pps_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
    // receiver hold-off long enough to back the item queue up into s_axis
    localparam int LONG_HOLD = 400;
    // a pull runs through EVAL, QRD and CRD in the back end, plus the output register
    localparam int SETTLE_CYCLES = 20;
    localparam int DRAIN_LIMIT = 5000;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [pps_pkg::S_TDATA_W-1:0]  s_axis_tdata = '0;   // conn_index[7:0], now[39:8]
    logic [pps_pkg::CMD_W-1:0]      s_axis_tuser = '0;   // cmd[1:0]
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic [pps_pkg::M_TDATA_W-1:0]  m_axis_tdata;        // pull_conn[7:0], pull_seq[23:8],
                                                         // pull_txq[39:24]
    logic [pps_pkg::KIND_W-1:0]     m_axis_tuser;        // kind[1:0]
    logic                           i_cfg_we = 1'b0;
    logic [pps_pkg::CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [pps_pkg::CFG_DATA_W-1:0] i_cfg_data = '0;

    pull_scoreboard sb = new();

    // sender burst bookkeeping and the long hold-off request to the receiver
    int burst_left = 0;
    bit rx_hold_ask = 1'b0;

    paced_pull_scheduler_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // generous cap: the slowest legal run is far below this
    initial begin
        #2_000_000;
        $display("** paced_pull_scheduler_top: FAILED **");
        $finish;
    end

    // result side: every accepted beat is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid === 1'b1 && m_axis_tready)
            sb.check_beat(m_axis_tuser, m_axis_tdata);
    end

    // receiver pacing: modes of random length, plus a long hold-off on request
    initial begin : rx_pacing
        int mode;
        int mode_left;
        int hold_left;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_ask) begin
                rx_hold_ask = 1'b0;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(8, 64);
                end
                mode_left--;
                case (mode)
                    0:       m_axis_tready <= 1'b1;                        // no stalls
                    1:       m_axis_tready <= ($urandom_range(0, 1) == 1); // coin toss
                    2:       m_axis_tready <= ($urandom_range(0, 3) == 0); // mostly stalled
                    default: m_axis_tready <= ((mode_left % 8) < 5);       // periodic stall
                endcase
            end
        end
    end

    // one input beat; a new burst may open with a gap of tvalid low
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] conn,
                             input logic [31:0] now);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {now, conn};
        do @(posedge i_clk); while (!(s_axis_tvalid && s_axis_tready));
        sb.take_item(cmd, conn, now);
    endtask

    // stop offering and wait for every owed result
    task automatic wait_drained();
        int waited;
        waited = 0;
        s_axis_tvalid <= 1'b0;
        do begin
            @(posedge i_clk);
            waited++;
        end while (sb.pending() != 0 && waited < DRAIN_LIMIT);
    endtask

    // register write, only issued with the block idle
    task automatic cfg_write(input logic [pps_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        sb.set_reg(idx, value);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [7:0] pick_conn();
        // a few hot connections so pull counters climb past one
        if ($urandom_range(0, 1) == 1) return 8'($urandom_range(0, 255));
        return 8'($urandom_range(0, 3));
    endfunction

    function automatic logic [1:0] pick_enq();
        return ($urandom_range(0, 2) == 0) ? pps_pkg::CMD_ENQ_PRIO : pps_pkg::CMD_ENQ_NORM;
    endfunction

    // time step between ticks: straddles the interval so about half are due
    function automatic logic [31:0] tick_step(input logic [31:0] interval);
        if (interval > 32'h7FFF_FFFE) return $urandom();
        return $urandom_range(0, 2 * interval + 2);
    endfunction

    // overfill one queue so the tail of the run is dropped
    task automatic flood(output int n);
        logic [1:0] cmd;
        cmd = pick_enq();
        n = pps_pkg::DEF_QUEUE_DEPTH + $urandom_range(1, 6);
        repeat (n) send_item(cmd, pick_conn(), $urandom());
    endtask

    task automatic run_directed();
        // priority on, short interval, all-ones transmit queue
        cfg_write(pps_pkg::CFG_INTERVAL, 32'd10);
        cfg_write(pps_pkg::CFG_PRIO_EN, 32'd1);
        cfg_write(pps_pkg::CFG_TXQ, 32'h0000_FFFF);
        send_item(pps_pkg::CMD_TICK, 8'h00, 32'd0);            // not due, nothing waiting
        send_item(pps_pkg::CMD_TICK, 8'hFF, 32'hFFFF_FFFF);    // slack 1, not due
        send_item(pps_pkg::CMD_ENQ_NORM, 8'h00, 32'hFFFF_FFFF);
        send_item(pps_pkg::CMD_ENQ_NORM, 8'hFF, 32'd0);
        send_item(pps_pkg::CMD_ENQ_PRIO, 8'h80, 32'h5555_5555);
        send_item(pps_pkg::CMD_ENQ_PRIO, 8'h7F, 32'hAAAA_AAAA);
        send_item(CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF);          // spare command does nothing
        send_item(pps_pkg::CMD_TICK, 8'h00, 32'd20);           // due from idle: priority first
        send_item(pps_pkg::CMD_TICK, 8'h00, 32'd25);           // not due
        send_item(pps_pkg::CMD_TICK, 8'h00, 32'd41);           // second priority entry
        send_item(pps_pkg::CMD_TICK, 8'h00, 32'd60);           // normal queue once priority is empty
        send_item(pps_pkg::CMD_TICK, 8'h00, 32'd61);           // late, deadline steps by one interval
        send_item(pps_pkg::CMD_TICK, 8'h00, 32'd75);           // due, nothing left: goes idle
        send_item(pps_pkg::CMD_TICK, 8'h00, 32'd80);
        wait_drained();

        // priority off, zero interval
        cfg_write(pps_pkg::CFG_PRIO_EN, 32'd0);
        cfg_write(pps_pkg::CFG_TXQ, 32'd0);
        cfg_write(pps_pkg::CFG_INTERVAL, 32'd0);
        send_item(pps_pkg::CMD_ENQ_PRIO, 8'h11, 32'd0);        // accepted but not served
        send_item(pps_pkg::CMD_ENQ_NORM, 8'h22, 32'd0);
        send_item(pps_pkg::CMD_TICK, 8'h00, 32'd80);           // equal to deadline: not due
        send_item(pps_pkg::CMD_TICK, 8'h00, 32'd81);
        send_item(pps_pkg::CMD_TICK, 8'h00, 32'd81);
        send_item(pps_pkg::CMD_TICK, 8'h00, 32'd82);           // priority entry stays put
        send_item(pps_pkg::CMD_TICK, 8'h00, 32'hFFFF_FFF0);
        wait_drained();

        // priority back on; time wraps past zero
        cfg_write(pps_pkg::CFG_PRIO_EN, 32'd1);
        send_item(pps_pkg::CMD_TICK, 8'h00, 32'd5);
        wait_drained();

        // widest interval: never due
        cfg_write(pps_pkg::CFG_INTERVAL, 32'hFFFF_FFFF);
        send_item(pps_pkg::CMD_ENQ_NORM, 8'h03, 32'd0);
        send_item(pps_pkg::CMD_TICK, 8'h00, 32'h1234_5678);
    endtask

    // one register setting with a random mix of sequences
    task automatic run_phase(input logic [31:0] interval, input bit prio_en,
                             input logic [15:0] txq, input logic [31:0] start_time,
                             input bit with_hold, input int n_items);
        int sent;
        int r;
        int n;
        logic [1:0] cmd;
        logic [31:0] tnow;
        wait_drained();
        cfg_write(pps_pkg::CFG_INTERVAL, interval);
        cfg_write(pps_pkg::CFG_PRIO_EN, {31'd0, prio_en});
        cfg_write(pps_pkg::CFG_TXQ, {16'd0, txq});
        tnow = start_time;
        sent = 0;
        if (with_hold) begin
            // receiver goes quiet while a flood backs up the input
            rx_hold_ask = 1'b1;
            flood(n);
            sent += n;
        end
        while (sent < n_items) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                // well formed: a few enqueues, then ticks on a moving clock
                n = $urandom_range(1, 6);
                repeat (n) send_item(pick_enq(), pick_conn(), $urandom());
                sent += n;
                n = $urandom_range(1, 8);
                repeat (n) begin
                    tnow = tnow + tick_step(interval);
                    send_item(pps_pkg::CMD_TICK, 8'($urandom()), tnow);
                end
                sent += n;
            end else if (r < 73) begin
                flood(n);
                sent += n;
            end else begin
                // noise, including the spare command and random times
                repeat ($urandom_range(1, 4)) begin
                    cmd = 2'($urandom_range(0, 3));
                    send_item(cmd, 8'($urandom()), $urandom());
                    if (cmd != CMD_UNUSED) sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        run_directed();

        run_phase(32'd1, 1'b1, 16'h0000, 32'd5, 1'b0, 84);
        run_phase(32'd50, 1'b0, 16'($urandom()), $urandom(), 1'b1, 84);
        run_phase(32'd1000, 1'b1, 16'hFFFF, $urandom(), 1'b0, 84);
        run_phase(32'h8000_0000, 1'b1, 16'($urandom()), $urandom(), 1'b0, 84);
        run_phase(32'($urandom_range(1, 300)), 1'b1, 16'($urandom()), 32'hFFFF_FF00, 1'b1, 84);
        run_phase(32'd0, 1'($urandom_range(0, 1)), 16'($urandom()), $urandom(), 1'b0, 84);

        wait_drained();
        // anything that shows up now has no prediction behind it
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));

        if (sb.errors == 0) begin
            $display("** paced_pull_scheduler_top: PASSED **");
        end else begin
            $display("** paced_pull_scheduler_top: FAILED **");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/pps_pkg.sv
rtl/pps_front.sv
rtl/pps_connq.sv
rtl/pps_back.sv
rtl/paced_pull_scheduler_top.sv
rtl/pps_checker.sv
bench/tb_paced_pull_scheduler_top.sv
